FILE: src/pods_pkg.sv
// Shared types and codes for the periodic and on-demand request scheduler.
// No dependencies; imported by every module of the block.
package pods_pkg;

    localparam int unsigned TIME_W = 32;
    localparam int unsigned ID_W   = 32;
    localparam int unsigned NUM_CLASSES = 3;

    typedef enum logic [1:0] {
        FUNC_TICK       = 2'd0,
        FUNC_COMPLETION = 2'd1,
        FUNC_REQUEST    = 2'd2,
        FUNC_UNUSED     = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        KIND_CRITICAL  = 2'd0,
        KIND_STANDARD  = 2'd1,
        KIND_ON_DEMAND = 2'd2,
        KIND_UNUSED    = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        CFG_CRITICAL_PERIOD = 2'd0,
        CFG_STANDARD_PERIOD = 2'd1,
        CFG_START_TIME      = 2'd2,
        CFG_UNUSED          = 2'd3
    } cfg_index_t;

    // Results of one input transaction: one bit per issued class, the latched
    // workpiece for an on-demand issue, and the busy flags after the step.
    typedef struct packed {
        logic [NUM_CLASSES-1:0] issue;
        logic                   present;
        logic [ID_W-1:0]        id;
        logic [NUM_CLASSES-1:0] busy;
    } group_t;

endpackage

FILE: src/pods_core.sv
// Input register, scheduler state and the single-pass decision logic.
// Depends on pods_pkg; feeds one result group per transaction to pods_emit.
module pods_core (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_write,
    input  logic [1:0]              cfg_index,
    input  logic [31:0]             cfg_data,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [1:0]              func,
    input  logic [31:0]             now,
    input  logic [1:0]              monitor_kind,
    input  logic                    workpiece_present,
    input  logic [31:0]             workpiece_id,
    input  logic                    grp_ready,
    output logic                    grp_load,
    output pods_pkg::group_t        grp_next
);
    import pods_pkg::*;

    // input register
    logic              in_valid_reg;
    func_t             func_reg;
    logic [TIME_W-1:0] now_reg;
    kind_t             kind_reg;
    logic              wp_present_reg;
    logic [ID_W-1:0]   wp_id_reg;

    // scheduler state
    logic [TIME_W-1:0] crit_period_reg;
    logic [TIME_W-1:0] std_period_reg;
    logic [TIME_W-1:0] crit_due_reg, crit_due_next;
    logic [TIME_W-1:0] std_due_reg, std_due_next;
    logic              crit_busy_reg, crit_busy_next;
    logic              std_busy_reg, std_busy_next;
    logic              od_busy_reg, od_busy_next;
    logic              od_pending_reg, od_pending_next;
    logic              latched_present_reg, latched_present_next;
    logic [ID_W-1:0]   latched_id_reg, latched_id_next;

    logic              advance;
    logic              issue_crit, issue_std, issue_od;
    logic [TIME_W:0]   crit_sum, std_sum;

    assign advance  = in_valid_reg && grp_ready;
    assign in_stall = in_valid_reg && !grp_ready;
    assign grp_load = advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            func_reg       <= func_t'(func);
            now_reg        <= now;
            kind_reg       <= kind_t'(monitor_kind);
            wp_present_reg <= workpiece_present;
            wp_id_reg      <= workpiece_id;
        end
    end

    assign crit_sum = {1'b0, now_reg} + {1'b0, crit_period_reg};
    assign std_sum  = {1'b0, now_reg} + {1'b0, std_period_reg};

    always_comb
    begin
        issue_crit           = 1'b0;
        issue_std            = 1'b0;
        issue_od             = 1'b0;
        crit_due_next        = crit_due_reg;
        std_due_next         = std_due_reg;
        crit_busy_next       = crit_busy_reg;
        std_busy_next        = std_busy_reg;
        od_busy_next         = od_busy_reg;
        od_pending_next      = od_pending_reg;
        latched_present_next = latched_present_reg;
        latched_id_next      = latched_id_reg;
        case (func_reg)
            FUNC_TICK:
            begin
                issue_crit = !crit_busy_reg && (now_reg >= crit_due_reg);
                issue_std  = !std_busy_reg && (now_reg >= std_due_reg);
                issue_od   = od_pending_reg && !od_busy_reg;
                if (issue_crit)
                begin
                    crit_busy_next = 1'b1;
                    // clamp at the largest time value
                    crit_due_next  = crit_sum[TIME_W] ? {TIME_W{1'b1}}
                                                      : crit_sum[TIME_W-1:0];
                end
                if (issue_std)
                begin
                    std_busy_next = 1'b1;
                    std_due_next  = std_sum[TIME_W] ? {TIME_W{1'b1}}
                                                    : std_sum[TIME_W-1:0];
                end
                if (issue_od)
                begin
                    od_pending_next = 1'b0;
                    od_busy_next    = 1'b1;
                end
            end
            FUNC_COMPLETION:
            begin
                case (kind_reg)
                    KIND_CRITICAL:  crit_busy_next = 1'b0;
                    KIND_STANDARD:  std_busy_next  = 1'b0;
                    KIND_ON_DEMAND: od_busy_next   = 1'b0;
                    default:        ;
                endcase
            end
            FUNC_REQUEST:
            begin
                latched_present_next = wp_present_reg;
                latched_id_next      = wp_present_reg ? wp_id_reg : '0;
                od_pending_next      = 1'b1;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        grp_next.issue   = {issue_od, issue_std, issue_crit};
        grp_next.present = latched_present_reg;
        grp_next.id      = latched_id_reg;
        grp_next.busy    = {od_busy_next, std_busy_next, crit_busy_next};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crit_period_reg     <= TIME_W'(1000);
            std_period_reg      <= TIME_W'(10000);
            crit_due_reg        <= '0;
            std_due_reg         <= '0;
            crit_busy_reg       <= 1'b0;
            std_busy_reg        <= 1'b0;
            od_busy_reg         <= 1'b0;
            od_pending_reg      <= 1'b0;
            latched_present_reg <= 1'b0;
            latched_id_reg      <= '0;
        end
        else
        begin
            if (advance)
            begin
                crit_due_reg        <= crit_due_next;
                std_due_reg         <= std_due_next;
                crit_busy_reg       <= crit_busy_next;
                std_busy_reg        <= std_busy_next;
                od_busy_reg         <= od_busy_next;
                od_pending_reg      <= od_pending_next;
                latched_present_reg <= latched_present_next;
                latched_id_reg      <= latched_id_next;
            end
            if (cfg_write)
            begin
                unique case (cfg_index_t'(cfg_index))
                    CFG_CRITICAL_PERIOD: crit_period_reg <= cfg_data;
                    CFG_STANDARD_PERIOD: std_period_reg  <= cfg_data;
                    CFG_START_TIME:
                    begin
                        crit_due_reg <= cfg_data;
                        std_due_reg  <= cfg_data;
                    end
                    default: ;
                endcase
            end
        end
    end

`ifndef ASSERT_OFF
    // only ticks issue requests
    a_issue_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && func_reg != FUNC_TICK) |-> (grp_next.issue == '0))
        else $error("request issued by a non-tick transaction");

    // an issued critical read leaves the class busy
    a_crit_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && grp_next.issue[0]) |=> crit_busy_reg)
        else $error("critical class not busy after issue");

    // due times only move forward between start-time writes
    a_due_forward: assert property (@(posedge clk) disable iff (!rst_n)
        !cfg_write |=> (crit_due_reg >= $past(crit_due_reg))
                       && (std_due_reg >= $past(std_due_reg)))
        else $error("due time moved backward");
`endif

endmodule

FILE: src/pods_emit.sv
// Result register that hands out the results of one group, one per cycle while out_stall is low.
// Depends on pods_pkg; loaded by pods_core.
module pods_emit (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             grp_load,
    input  pods_pkg::group_t grp_next,
    output logic             grp_ready,
    output logic             out_valid,
    input  logic             out_stall,
    output logic             request_valid,
    output logic [1:0]       request_kind,
    output logic             target_present,
    output logic [31:0]      target_id,
    output logic             critical_busy,
    output logic             standard_busy,
    output logic             on_demand_busy,
    output logic             last
);
    import pods_pkg::*;

    logic                   valid_reg;
    logic [NUM_CLASSES-1:0] issue_reg;
    logic                   present_reg;
    logic [ID_W-1:0]        id_reg;
    logic [NUM_CLASSES-1:0] busy_reg;
    logic [NUM_CLASSES-1:0] issue_rest;
    logic                   take;
    kind_t                  kind;

    // drop the lowest pending issue once it is taken
    assign issue_rest = issue_reg & (issue_reg - NUM_CLASSES'(1));
    assign last       = (issue_rest == '0);
    assign take       = valid_reg && !out_stall;
    assign grp_ready  = !valid_reg || (take && last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (grp_ready)
        begin
            valid_reg <= grp_load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (grp_ready && grp_load)
        begin
            issue_reg   <= grp_next.issue;
            present_reg <= grp_next.present;
            id_reg      <= grp_next.id;
            busy_reg    <= grp_next.busy;
        end
        else if (take && !last)
        begin
            issue_reg <= issue_rest;
        end
    end

    always_comb
    begin
        if (issue_reg[0])
        begin
            kind = KIND_CRITICAL;
        end
        else if (issue_reg[1])
        begin
            kind = KIND_STANDARD;
        end
        else if (issue_reg[2])
        begin
            kind = KIND_ON_DEMAND;
        end
        else
        begin
            kind = KIND_CRITICAL;
        end
    end

    assign out_valid      = valid_reg;
    assign request_valid  = (issue_reg != '0);
    assign request_kind   = kind;
    assign target_present = (kind == KIND_ON_DEMAND) && present_reg;
    assign target_id      = target_present ? id_reg : '0;
    assign critical_busy  = busy_reg[0];
    assign standard_busy  = busy_reg[1];
    assign on_demand_busy = busy_reg[2];

`ifndef ASSERT_OFF
    // a group is never loaded over results still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !(take && last)) |=> valid_reg)
        else $error("pending results lost");

    // a non-final result is followed by another result of the same group
    a_group_cont: assert property (@(posedge clk) disable iff (!rst_n)
        (take && !last) |=> (valid_reg && $stable(busy_reg)))
        else $error("result group cut short");
`endif

endmodule

FILE: src/periodic_and_on_demand_request_scheduler_top.sv
// Top level of the periodic and on-demand request scheduler.
// Depends on pods_pkg, pods_core and pods_emit.
//
// Accepts one transaction per cycle into an input register while in_stall is
// low. The scheduling decision is made combinationally from the input
// register, and its results load the result register once that register is
// ready to take a new group. Results leave one per cycle while out_stall is
// low: a tick that issues k reads (k up to 3) yields k results, every other
// transaction and a tick that issues none yield one. The input side stalls
// while a transaction waits in the input register and the result register
// still holds results that are not taken, that is while a multi-result group
// drains or while the receiver stalls. With no output stall, the output
// serializer, one result per cycle, sets the sustained rate.
// Configuration writes take effect at the next clock edge and must be made
// while no transaction is in progress.
module periodic_and_on_demand_request_scheduler_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  func,
    input  logic [31:0] now,
    input  logic [1:0]  monitor_kind,
    input  logic        workpiece_present,
    input  logic [31:0] workpiece_id,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        request_valid,
    output logic [1:0]  request_kind,
    output logic        target_present,
    output logic [31:0] target_id,
    output logic        critical_busy,
    output logic        standard_busy,
    output logic        on_demand_busy,
    output logic        last
);
    import pods_pkg::*;

    logic   grp_ready;
    logic   grp_load;
    group_t grp_next;

    pods_core u_core (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_write         (cfg_write),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .func              (func),
        .now               (now),
        .monitor_kind      (monitor_kind),
        .workpiece_present (workpiece_present),
        .workpiece_id      (workpiece_id),
        .grp_ready         (grp_ready),
        .grp_load          (grp_load),
        .grp_next          (grp_next)
    );

    pods_emit u_emit (
        .clk            (clk),
        .rst_n          (rst_n),
        .grp_load       (grp_load),
        .grp_next       (grp_next),
        .grp_ready      (grp_ready),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .request_valid  (request_valid),
        .request_kind   (request_kind),
        .target_present (target_present),
        .target_id      (target_id),
        .critical_busy  (critical_busy),
        .standard_busy  (standard_busy),
        .on_demand_busy (on_demand_busy),
        .last           (last)
    );

endmodule
